// ===== design/lve_pkg.sv =====
// Shared types, constants and saturation helpers for the limb velocity estimator.
`timescale 1ns / 1ps
package lve_pkg;

  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 72;
  localparam int VEL_W       = 24;
  localparam int COORD_W     = 16;
  localparam int TIME_W      = 32;
  localparam int ENTRY_W     = 2 * COORD_W + TIME_W + 1;
  localparam int HIST_REG_W  = 7;
  localparam int MIN_LENGTH  = 20;
  localparam int ALPHA_Q16   = 19661;
  localparam int BETA_Q16    = 45875;
  localparam int VEL_SCALE   = 16000;
  localparam int MEAN_W      = 32;
  localparam int DIV_W       = 35;
  localparam int DIV_PAD     = 64 - DIV_W;
  localparam int RAD_W       = 64;
  localparam int REM_W       = 36;
  localparam int SQRT_STEPS  = 32;
  localparam int STEP_W      = 6;

  localparam logic REG_HISTORY_LENGTH = 1'b0;

  typedef enum logic {
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic                     start;
    alu_op_t                  op;
    logic [RAD_W-1:0]         opa;
    logic [31:0]              opb;
  } alu_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic [DIV_W-1:0]         result;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD,
    ST_DATA,
    ST_PX,
    ST_PXW,
    ST_PY,
    ST_PYW,
    ST_MX,
    ST_MXW,
    ST_MY,
    ST_MYW,
    ST_SQX,
    ST_SQY,
    ST_SQS,
    ST_SQW,
    ST_EA,
    ST_EB,
    ST_EC,
    ST_OUT
  } lve_state_t;

  function automatic logic signed [VEL_W-1:0] sat_s24(input logic signed [63:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = VEL_W'(v);
    end
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] sat_u24(input logic signed [63:0] v);
    logic [VEL_W-1:0] r;
    if (v < 64'sd0) begin
      r = '0;
    end else if (v > 64'sd16777215) begin
      r = '1;
    end else begin
      r = VEL_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/lve_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lve_alu.sv =====
// Shared bit-serial unit: restoring divide and digit-by-digit square root.
`timescale 1ns / 1ps
module lve_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  lve_pkg::alu_req_t req,
  output lve_pkg::alu_rsp_t rsp
);
  import lve_pkg::*;

  logic [RAD_W-1:0]  src_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  res_r;
  logic [31:0]       dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  alu_op_t           op_r;

  logic [REM_W-1:0]  rshift;
  logic [REM_W-1:0]  trial;
  logic              take;
  logic              last;

  always_comb begin
    if (op_r == ALU_DIV) begin
      rshift = {rem_r[REM_W-2:0], src_r[RAD_W-1]};
      trial  = REM_W'(dvs_r);
      last   = (cnt_r == STEP_W'(DIV_W - 1));
    end else begin
      rshift = {rem_r[REM_W-3:0], src_r[RAD_W-1:RAD_W-2]};
      trial  = REM_W'({res_r[31:0], 2'b01});
      last   = (cnt_r == STEP_W'(SQRT_STEPS - 1));
    end
    take = (rshift >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
        dvs_r  <= req.opb;
        rem_r  <= '0;
        res_r  <= '0;
        src_r  <= (req.op == ALU_DIV) ? {req.opa[DIV_W-1:0], DIV_PAD'(0)} : req.opa;
      end else if (busy_r) begin
        rem_r <= take ? (rshift - trial) : rshift;
        res_r <= {res_r[DIV_W-2:0], take};
        src_r <= (op_r == ALU_DIV) ? {src_r[RAD_W-2:0], 1'b0} : {src_r[RAD_W-3:0], 2'b00};
        cnt_r <= cnt_r + STEP_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== design/limb_velocity_estimator.sv =====
// Top level: per-channel sample rings, scan sequencer and EMA velocity output.
`timescale 1ns / 1ps
// One request is taken at a time; in_tready is high only while the sequencer is idle,
// and the result waits in an output register so the next request can enter at once.
// The cost of a request grows with S, the number of ring entries scanned (at most the fill
// minus one, stopping after VELOCITY_WINDOW valid samples), and with P, the number of usable
// sample pairs (at most VELOCITY_WINDOW - 1); the mean, root and EMA steps run only when
// at least one pair is usable.
// It is set by the one shared divide / square-root unit, which retires one bit per cycle
// (35 quotient bits, 32 root bits), and by the ring RAM's registered read port, which takes
// a read state and a data state per entry. Requests for a channel at or above
// CHANNEL_COUNT return an inactive result and touch no state. The ring needs no
// clearing pass after reset.
module limb_velocity_estimator #(
  parameter int HISTORY_DEPTH   = 64,
  parameter int VELOCITY_WINDOW = 10,
  parameter int CHANNEL_COUNT   = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // time_ms, a_x, a_y, a_seen, b_x, b_y, b_seen, zero fill
  input  logic [lve_pkg::IN_DATA_W-1:0]    in_tdata,
  // channel
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // vel_x, vel_y, speed
  output logic [lve_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_channel, active
  output logic [2:0]                       out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import lve_pkg::*;

  localparam int PTR_W     = $clog2(HISTORY_DEPTH);
  localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int RAM_DEPTH = CHANNEL_COUNT * HISTORY_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int N_W       = $clog2(VELOCITY_WINDOW + 1);
  localparam int SUM_W     = 31 + $clog2(VELOCITY_WINDOW);

  lve_state_t state_r, state_nxt;

  logic [HIST_REG_W-1:0] hl_r;
  logic [1:0]            ch_r;
  logic [COORD_W-1:0]    samp_x_r, samp_y_r;
  logic [TIME_W-1:0]     samp_t_r;
  logic                  samp_v_r;

  logic [PTR_W-1:0]          head_r [CHANNEL_COUNT];
  logic [FILL_W-1:0]         fill_r [CHANNEL_COUNT];
  logic signed [VEL_W-1:0]   svx_r  [CHANNEL_COUNT];
  logic signed [VEL_W-1:0]   svy_r  [CHANNEL_COUNT];
  logic [VEL_W-1:0]          ssp_r  [CHANNEL_COUNT];
  logic                      act_r  [CHANNEL_COUNT];

  logic [PTR_W-1:0]          ptr_r;
  logic [FILL_W-1:0]         idx_r;
  logic [N_W-1:0]            n_r, pcnt_r;
  logic [COORD_W-1:0]        prev_x_r, prev_y_r;
  logic [TIME_W-1:0]         prev_t_r;
  logic signed [COORD_W:0]   dx_r, dy_r;
  logic [TIME_W-1:0]         dt_r;
  logic signed [SUM_W-1:0]   sumx_r, sumy_r;
  logic signed [MEAN_W-1:0]  mx_r, my_r, ms_r;
  logic [63:0]               sq_r;
  logic signed [63:0]        acc_r, prod_r;
  logic [1:0]                k_r;

  logic                      out_valid_r, out_act_r;
  logic [1:0]                out_ch_r;
  logic [VEL_W-1:0]          out_vx_r, out_vy_r, out_sp_r;

  // Unpacked request fields.
  logic [TIME_W-1:0]  in_t;
  logic [COORD_W-1:0] in_ax, in_ay, in_bx, in_by;
  logic               in_as, in_bs;
  assign in_t  = in_tdata[31:0];
  assign in_ax = in_tdata[47:32];
  assign in_ay = in_tdata[63:48];
  assign in_as = in_tdata[64];
  assign in_bx = in_tdata[80:65];
  assign in_by = in_tdata[96:81];
  assign in_bs = in_tdata[97];

  logic               in_acc;
  logic [CH_W-1:0]    chi;
  logic               ch_ok;
  logic [FILL_W-1:0]  len;
  logic [FILL_W:0]    fill_inc;
  logic [FILL_W-1:0]  fill_new;
  logic [ADDR_W-1:0]  base;
  logic               scan_more;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic [TIME_W-1:0]  rd_t;
  logic               rd_v;
  logic [TIME_W-1:0]  pair_dt;
  logic               pair_ok;
  logic               out_free;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [MEAN_W-1:0] m_k;
  logic signed [31:0] old16_k;
  logic signed [63:0] ema_v, fin_v;
  logic [SUM_W-2:0]   sum_mag;

  assign in_acc   = in_tvalid && in_tready;
  assign chi      = CH_W'(ch_r);
  assign ch_ok    = int'(ch_r) < CHANNEL_COUNT;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    if (int'(hl_r) < MIN_LENGTH) begin
      len = FILL_W'(MIN_LENGTH);
    end else if (int'(hl_r) > HISTORY_DEPTH) begin
      len = FILL_W'(HISTORY_DEPTH);
    end else begin
      len = FILL_W'(hl_r);
    end
    fill_inc = {1'b0, fill_r[chi]} + (FILL_W + 1)'(1);
    fill_new = (fill_inc > {1'b0, len}) ? len : fill_inc[FILL_W-1:0];
  end

  assign base      = ADDR_W'(ch_r) * ADDR_W'(HISTORY_DEPTH);
  assign ram_waddr = base + ADDR_W'(head_r[chi]);
  assign ram_raddr = base + ADDR_W'(ptr_r);
  assign ram_wdata = {samp_v_r, samp_t_r, samp_y_r, samp_x_r};
  assign rd_x      = ram_rdata[15:0];
  assign rd_y      = ram_rdata[31:16];
  assign rd_t      = ram_rdata[63:32];
  assign rd_v      = ram_rdata[64];
  assign pair_dt   = prev_t_r - rd_t;
  assign pair_ok   = (n_r != '0) && (pair_dt != '0) && !pair_dt[TIME_W-1];
  assign scan_more = (idx_r < fill_r[chi]) && (n_r < N_W'(VELOCITY_WINDOW));

  lve_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lve_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // EMA operand selection for the component under work.
  always_comb begin
    case (k_r)
      2'd0:    begin m_k = mx_r; old16_k = {{4{svx_r[chi][VEL_W-1]}}, svx_r[chi], 4'b0}; end
      2'd1:    begin m_k = my_r; old16_k = {{4{svy_r[chi][VEL_W-1]}}, svy_r[chi], 4'b0}; end
      default: begin m_k = ms_r; old16_k = {4'b0, ssp_r[chi], 4'b0}; end
    endcase
    ema_v = (acc_r + prod_r + 64'sd524288) >>> 20;
    fin_v = act_r[chi] ? ema_v : ((64'(m_k) + 64'sd8) >>> 4);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) begin
                  state_nxt = (int'(in_tuser) < CHANNEL_COUNT) ? ST_WRITE : ST_OUT;
                end
      ST_WRITE: state_nxt = ST_RD;
      ST_RD: begin
        if (scan_more) begin
          state_nxt = ST_DATA;
        end else if (n_r < N_W'(2) || pcnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MX;
        end
      end
      ST_DATA:  state_nxt = (rd_v && pair_ok) ? ST_PX : ST_RD;
      ST_PX:    state_nxt = ST_PXW;
      ST_PXW:   if (alu_rsp.done) begin
                  state_nxt = ST_PY;
                end
      ST_PY:    state_nxt = ST_PYW;
      ST_PYW:   if (alu_rsp.done) begin
                  state_nxt = ST_RD;
                end
      ST_MX:    state_nxt = ST_MXW;
      ST_MXW:   if (alu_rsp.done) begin
                  state_nxt = ST_MY;
                end
      ST_MY:    state_nxt = ST_MYW;
      ST_MYW:   if (alu_rsp.done) begin
                  state_nxt = ST_SQX;
                end
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SQS;
      ST_SQS:   state_nxt = ST_SQW;
      ST_SQW:   if (alu_rsp.done) begin
                  state_nxt = ST_EA;
                end
      ST_EA:    state_nxt = ST_EB;
      ST_EB:    state_nxt = ST_EC;
      ST_EC:    state_nxt = (k_r == 2'd2) ? ST_OUT : ST_EA;
      ST_OUT:   if (out_free) begin
                  state_nxt = ST_IDLE;
                end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready   = 1'b0;
    ram_we      = 1'b0;
    alu_req     = '0;
    alu_req.op  = ALU_DIV;
    mul_a       = '0;
    mul_b       = '0;
    sum_mag     = '0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_WRITE: ram_we = 1'b1;
      ST_PX: begin
        alu_req.start = 1'b1;
        alu_req.opa   = RAD_W'(32'(dx_r[COORD_W] ? -dx_r : dx_r) * 32'(VEL_SCALE));
        alu_req.opb   = dt_r;
      end
      ST_PY: begin
        alu_req.start = 1'b1;
        alu_req.opa   = RAD_W'(32'(dy_r[COORD_W] ? -dy_r : dy_r) * 32'(VEL_SCALE));
        alu_req.opb   = dt_r;
      end
      ST_MX: begin
        sum_mag       = sumx_r[SUM_W-1] ? (SUM_W-1)'(-sumx_r) : (SUM_W-1)'(sumx_r);
        alu_req.start = 1'b1;
        alu_req.opa   = RAD_W'(sum_mag);
        alu_req.opb   = 32'(pcnt_r);
      end
      ST_MY: begin
        sum_mag       = sumy_r[SUM_W-1] ? (SUM_W-1)'(-sumy_r) : (SUM_W-1)'(sumy_r);
        alu_req.start = 1'b1;
        alu_req.opa   = RAD_W'(sum_mag);
        alu_req.opb   = 32'(pcnt_r);
      end
      ST_SQX: begin mul_a = mx_r; mul_b = mx_r; end
      ST_SQY: begin mul_a = my_r; mul_b = my_r; end
      ST_SQS: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_req.opa   = sq_r + 64'(prod_r);
      end
      ST_EA: begin mul_a = 32'sd19661; mul_b = m_k; end
      ST_EB: begin mul_a = 32'sd45875; mul_b = old16_k; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_HISTORY_LENGTH) ? 32'(hl_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_HISTORY_LENGTH) begin
      hl_r <= cfg_pwdata[HIST_REG_W-1:0];
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      pcnt_r      <= '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        head_r[c] <= '0;
        fill_r[c] <= '0;
        act_r[c]  <= 1'b0;
        svx_r[c]  <= '0;
        svy_r[c]  <= '0;
        ssp_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: if (in_acc) begin
          ch_r     <= in_tuser;
          samp_t_r <= in_t;
          samp_v_r <= in_as || in_bs;
          if (in_as && in_bs) begin
            samp_x_r <= COORD_W'(({1'b0, in_ax} + {1'b0, in_bx}) >> 1);
            samp_y_r <= COORD_W'(({1'b0, in_ay} + {1'b0, in_by}) >> 1);
          end else if (in_as) begin
            samp_x_r <= in_ax;
            samp_y_r <= in_ay;
          end else if (in_bs) begin
            samp_x_r <= in_bx;
            samp_y_r <= in_by;
          end else begin
            samp_x_r <= '0;
            samp_y_r <= '0;
          end
        end
        ST_WRITE: begin
          head_r[chi] <= (head_r[chi] == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                   : head_r[chi] + PTR_W'(1);
          fill_r[chi] <= fill_new;
          // newest sample is already held: start the scan one entry back
          ptr_r    <= (head_r[chi] == '0) ? PTR_W'(HISTORY_DEPTH - 1) : head_r[chi] - PTR_W'(1);
          idx_r    <= FILL_W'(1);
          n_r      <= samp_v_r ? N_W'(1) : '0;
          pcnt_r   <= '0;
          prev_x_r <= samp_x_r;
          prev_y_r <= samp_y_r;
          prev_t_r <= samp_t_r;
          sumx_r   <= '0;
          sumy_r   <= '0;
        end
        ST_RD: begin
          if (scan_more) begin
            ptr_r <= (ptr_r == '0) ? PTR_W'(HISTORY_DEPTH - 1) : ptr_r - PTR_W'(1);
          end else if (n_r < N_W'(2)) begin
            act_r[chi] <= 1'b0;
            svx_r[chi] <= '0;
            svy_r[chi] <= '0;
            ssp_r[chi] <= '0;
          end else if (pcnt_r == '0) begin
            act_r[chi] <= 1'b0;
          end
        end
        ST_DATA: begin
          idx_r <= idx_r + FILL_W'(1);
          if (rd_v) begin
            dx_r     <= $signed({1'b0, prev_x_r}) - $signed({1'b0, rd_x});
            dy_r     <= $signed({1'b0, prev_y_r}) - $signed({1'b0, rd_y});
            dt_r     <= pair_dt;
            n_r      <= n_r + N_W'(1);
            prev_x_r <= rd_x;
            prev_y_r <= rd_y;
            prev_t_r <= rd_t;
          end
        end
        ST_PXW: if (alu_rsp.done) begin
          sumx_r <= dx_r[COORD_W] ? sumx_r - SUM_W'(alu_rsp.result)
                                  : sumx_r + SUM_W'(alu_rsp.result);
        end
        ST_PYW: if (alu_rsp.done) begin
          sumy_r <= dy_r[COORD_W] ? sumy_r - SUM_W'(alu_rsp.result)
                                  : sumy_r + SUM_W'(alu_rsp.result);
          pcnt_r <= pcnt_r + N_W'(1);
        end
        ST_MXW: if (alu_rsp.done) begin
          mx_r <= sumx_r[SUM_W-1] ? -MEAN_W'(alu_rsp.result) : MEAN_W'(alu_rsp.result);
        end
        ST_MYW: if (alu_rsp.done) begin
          my_r <= sumy_r[SUM_W-1] ? -MEAN_W'(alu_rsp.result) : MEAN_W'(alu_rsp.result);
        end
        ST_SQY: sq_r <= 64'(prod_r);
        ST_SQW: if (alu_rsp.done) begin
          ms_r <= MEAN_W'(alu_rsp.result);
          k_r  <= 2'd0;
        end
        ST_EB: acc_r <= prod_r;
        ST_EC: begin
          case (k_r)
            2'd0:    svx_r[chi] <= sat_s24(fin_v);
            2'd1:    svy_r[chi] <= sat_s24(fin_v);
            default: ssp_r[chi] <= sat_u24(fin_v);
          endcase
          k_r <= k_r + 2'd1;
          if (k_r == 2'd2) begin
            act_r[chi] <= 1'b1;
          end
        end
        ST_OUT: if (out_free) begin
          out_ch_r    <= ch_r;
          out_act_r   <= ch_ok && act_r[chi];
          out_vx_r    <= (ch_ok && act_r[chi]) ? svx_r[chi] : '0;
          out_vy_r    <= (ch_ok && act_r[chi]) ? svy_r[chi] : '0;
          out_sp_r    <= (ch_ok && act_r[chi]) ? ssp_r[chi] : '0;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sp_r, out_vy_r, out_vx_r};
  assign out_tuser  = {out_act_r, out_ch_r};

`ifndef SYNTHESIS
  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_act_r |-> out_vx_r == '0 && out_vy_r == '0 && out_sp_r == '0)
    else $error("inactive result carries nonzero velocity");

  a_no_pairs_without_samples: assert property (@(posedge clk) disable iff (!rst_n)
    n_r == '0 |-> pcnt_r == '0)
    else $error("pair counted with no valid sample");

  a_pairs_below_samples: assert property (@(posedge clk) disable iff (!rst_n)
    n_r != '0 |-> pcnt_r < n_r)
    else $error("more pairs than samples");

  a_alu_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == ST_PXW || state_r == ST_PYW || state_r == ST_MXW ||
                     state_r == ST_MYW || state_r == ST_SQW)
    else $error("arithmetic unit finished outside a wait state");
`endif

endmodule

// ===== sim/lve_velocity_checker.sv =====
// Watches the limb velocity estimator channels, predicts each estimate and compares.
`timescale 1ns / 1ps
module lve_velocity_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [lve_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [lve_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic [2:0]                      out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              error_count,
  output int                              pending_count
);
  import lve_pkg::*;

  localparam int DEPTH  = 64;
  localparam int WINDOW = 10;
  localparam int CHANS  = 4;

  typedef struct packed {
    logic [1:0]              chan;
    logic                    active;
    logic [VEL_W-1:0]        vx;
    logic [VEL_W-1:0]        vy;
    logic [VEL_W-1:0]        speed;
  } estimate_t;

  logic [COORD_W-1:0] ring_x    [CHANS][DEPTH];
  logic [COORD_W-1:0] ring_y    [CHANS][DEPTH];
  logic [TIME_W-1:0]  ring_t    [CHANS][DEPTH];
  logic               ring_ok   [CHANS][DEPTH];
  int                 head      [CHANS];
  int                 fill      [CHANS];
  longint             ema_vx    [CHANS];
  longint             ema_vy    [CHANS];
  longint             ema_speed [CHANS];
  logic               tracking  [CHANS];
  int                 hist_len;
  estimate_t          expected_estimates[$];

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic longint round20(input longint v);
    return (v + (64'sd1 <<< 19)) >>> 20;
  endfunction

  function automatic longint clip_s24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint clip_u24(input longint v);
    if (v > 16777215) return 16777215;
    if (v < 0) return 0;
    return v;
  endfunction

  task automatic predict_estimate(input logic [1:0] ch, input logic [IN_DATA_W-1:0] d,
                                  output estimate_t est);
    logic [TIME_W-1:0]  t;
    logic [COORD_W-1:0] ax, ay, bx, by, x, y;
    logic               as, bs, ok;
    logic [TIME_W-1:0]  dt;
    longint             wx[WINDOW], wy[WINDOW];
    logic [TIME_W-1:0]  wt[WINDOW];
    int                 n, len, p, cnt;
    longint             sumx, sumy, mx, my, ms;
    t  = d[31:0];
    ax = d[47:32];
    ay = d[63:48];
    as = d[64];
    bx = d[80:65];
    by = d[96:81];
    bs = d[97];
    ok = 1'b1;
    if (as && bs) begin
      x = COORD_W'((17'(ax) + 17'(bx)) >> 1);
      y = COORD_W'((17'(ay) + 17'(by)) >> 1);
    end else if (as) begin
      x = ax; y = ay;
    end else if (bs) begin
      x = bx; y = by;
    end else begin
      x = '0; y = '0; ok = 1'b0;
    end
    len = hist_len < MIN_LENGTH ? MIN_LENGTH : (hist_len > DEPTH ? DEPTH : hist_len);
    p = head[ch];
    ring_x[ch][p] = x;
    ring_y[ch][p] = y;
    ring_t[ch][p] = t;
    ring_ok[ch][p] = ok;
    head[ch] = (p + 1) % DEPTH;
    fill[ch] = fill[ch] + 1 > len ? len : fill[ch] + 1;

    n = 0;
    for (int i = 0; i < fill[ch] && n < WINDOW; i++) begin
      p = (head[ch] + DEPTH - 1 - i) % DEPTH;
      if (ring_ok[ch][p]) begin
        wx[n] = ring_x[ch][p];
        wy[n] = ring_y[ch][p];
        wt[n] = ring_t[ch][p];
        n++;
      end
    end
    if (n < 2) begin
      tracking[ch] = 1'b0;
      ema_vx[ch] = 0;
      ema_vy[ch] = 0;
      ema_speed[ch] = 0;
    end else begin
      sumx = 0; sumy = 0; cnt = 0;
      for (int i = 0; i + 1 < n; i++) begin
        dt = wt[i] - wt[i+1];
        if (dt != 0 && !dt[31]) begin
          sumx += (wx[i] - wx[i+1]) * 16000 / longint'(dt);
          sumy += (wy[i] - wy[i+1]) * 16000 / longint'(dt);
          cnt++;
        end
      end
      if (cnt == 0) begin
        tracking[ch] = 1'b0;
      end else begin
        mx = sumx / cnt;
        my = sumy / cnt;
        ms = longint'(isqrt(longint'(mx * mx) + longint'(my * my)));
        if (tracking[ch]) begin
          ema_vx[ch] = clip_s24(round20(ALPHA_Q16 * mx + BETA_Q16 * (ema_vx[ch] * 16)));
          ema_vy[ch] = clip_s24(round20(ALPHA_Q16 * my + BETA_Q16 * (ema_vy[ch] * 16)));
          ema_speed[ch] = clip_u24(round20(ALPHA_Q16 * ms + BETA_Q16 * (ema_speed[ch] * 16)));
        end else begin
          ema_vx[ch] = clip_s24((mx + 8) >>> 4);
          ema_vy[ch] = clip_s24((my + 8) >>> 4);
          ema_speed[ch] = clip_u24((ms + 8) >>> 4);
        end
        tracking[ch] = 1'b1;
      end
    end
    est.chan   = ch;
    est.active = tracking[ch];
    est.vx     = tracking[ch] ? VEL_W'(ema_vx[ch]) : '0;
    est.vy     = tracking[ch] ? VEL_W'(ema_vy[ch]) : '0;
    est.speed  = tracking[ch] ? VEL_W'(ema_speed[ch]) : '0;
  endtask

  always @(posedge clk) begin
    estimate_t want, got;
    if (!rst_n) begin
      for (int c = 0; c < CHANS; c++) begin
        head[c] = 0; fill[c] = 0; tracking[c] = 1'b0;
        ema_vx[c] = 0; ema_vy[c] = 0; ema_speed[c] = 0;
      end
      hist_len = 64;
      error_count = 0;
      expected_estimates.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        hist_len = int'(cfg_pwdata[HIST_REG_W-1:0]);
      if (in_tvalid && in_tready) begin
        predict_estimate(in_tuser, in_tdata, want);
        expected_estimates.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.chan   = out_tuser[1:0];
        got.active = out_tuser[2];
        got.vx     = out_tdata[23:0];
        got.vy     = out_tdata[47:24];
        got.speed  = out_tdata[71:48];
        if (expected_estimates.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected estimate %h", got);
        end else begin
          want = expected_estimates.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("estimate mismatch: ch %0d/%0d act %0d/%0d vx %h/%h vy %h/%h sp %h/%h",
                       want.chan, got.chan, want.active, got.active, want.vx, got.vx,
                       want.vy, got.vy, want.speed, got.speed);
          end
        end
      end
    end
    pending_count = expected_estimates.size();
  end

endmodule

// ===== sim/tb.sv =====
// Stimulus, clocking and verdict for the limb velocity estimator testbench.
`timescale 1ns / 1ps
module tb;
  import lve_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid, in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [2:0]             out_tuser;
  logic                   cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata, cfg_prdata;
  int                     error_count, pending_count;
  int                     send_idle_pct, recv_stall_pct;
  longint                 cycle_count;
  logic [31:0]            last_time [4];
  logic [15:0]            pos_x [4], pos_y [4];
  logic                   occluded [4];

  limb_velocity_estimator dut (.*);

  lve_velocity_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 6000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial out_tready = 1'b0;
  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_stall_pct);

  task automatic send_request(input logic [1:0] ch, input logic [31:0] t,
                              input logic [15:0] ax, ay, input logic as,
                              input logic [15:0] bx, by, input logic bs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = ch;
    in_tdata  = {6'd0, bs, by, bx, as, ay, ax, t};
    in_tvalid = 1'b1;
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = 1'b1;
    cfg_paddr = addr; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  // Mostly smooth motion per channel, with occlusion runs and odd timestamps.
  task automatic random_request;
    logic [1:0]  ch;
    int          r;
    logic [31:0] t;
    logic        as, bs;
    logic [15:0] bx, by;
    ch = $urandom_range(3);
    r = $urandom_range(99);
    if (r < 70)      t = last_time[ch] + $urandom_range(60, 1);
    else if (r < 77) t = last_time[ch];
    else if (r < 83) t = last_time[ch] - $urandom_range(40, 1);
    else if (r < 89) t = $urandom;
    else if (r < 95) t = last_time[ch] + $urandom_range(200000, 1000);
    else             t = last_time[ch] + 32'h7FFF_FFFF + $urandom_range(1);
    last_time[ch] = t;
    if ($urandom_range(99) < 15) begin
      pos_x[ch] = $urandom; pos_y[ch] = $urandom;
    end else begin
      pos_x[ch] += 16'($urandom_range(400)) - 16'd200;
      pos_y[ch] += 16'($urandom_range(400)) - 16'd200;
    end
    if ($urandom_range(99) < 4) occluded[ch] = ~occluded[ch];
    r = $urandom_range(99);
    as = !occluded[ch] && r < 85;
    bs = !occluded[ch] && (r >= 60 || r < 40);
    if ($urandom_range(99) < 10) begin
      bx = $urandom; by = $urandom;
    end else begin
      bx = pos_x[ch] + 16'($urandom_range(60)); by = pos_y[ch] + 16'($urandom_range(60));
    end
    send_request(ch, t, pos_x[ch], pos_y[ch], as, bx, by, bs);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int c = 0; c < 4; c++) begin
      last_time[c] = $urandom; pos_x[c] = $urandom; pos_y[c] = $urandom; occluded[c] = 1'b0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Extremes, visibility combinations, zero and backward dt, wrap.
    send_request(0, 32'd0, 16'd0, 16'd0, 1, 16'd0, 16'd0, 1);
    send_request(0, 32'd1, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1);
    send_request(0, 32'd2, 16'd0, 16'd0, 1, 16'hFFFF, 16'hFFFF, 0);
    send_request(0, 32'd3, 16'hFFFF, 16'h0000, 0, 16'h0000, 16'hFFFF, 1);
    send_request(0, 32'd3, 16'h1234, 16'h5678, 0, 16'h9ABC, 16'hDEF0, 0);
    send_request(0, 32'd3, 16'h1234, 16'h5678, 1, 16'h9ABD, 16'hDEF1, 1);
    send_request(1, 32'hFFFF_FFF0, 16'd100, 16'd100, 1, 16'd102, 16'd98, 1);
    send_request(1, 32'h0000_0005, 16'd300, 16'd50, 1, 16'd300, 16'd50, 1);
    send_request(1, 32'h0000_0001, 16'd200, 16'd60, 1, 16'd200, 16'd60, 1);
    send_request(1, 32'h8000_0001, 16'd200, 16'd60, 1, 16'd200, 16'd60, 1);
    send_request(2, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA, 1);
    send_request(2, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA, 1);
    send_request(2, 32'h5555_5555, 16'hAAAA, 16'h5555, 1, 16'hAAAA, 16'h5555, 1);
    for (int i = 0; i < 10; i++)
      send_request(3, 32'd1000 + 32'(i), 16'd0, 16'd0, 0, 16'd0, 16'd0, 0);
    send_request(3, 32'd2000, 16'd5, 16'd5, 1, 16'd5, 16'd5, 0);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: write_reg(3'd0, 32'd20);
        1: write_reg(3'd0, 32'd127);
        2: write_reg(3'd0, 32'd5);
        3: write_reg(3'd0, 32'd33);
        default: begin
          write_reg(3'd4, 32'd21);
          write_reg(3'd0, 32'd64);
        end
      endcase
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        3: begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // In the last phase, idling and output stalls start after the first stretch of requests.
      for (int i = 0; i < 160; i++) begin
        if (i == 30 && phase == 4) begin send_idle_pct = 18; recv_stall_pct = 61; end
        random_request();
      end
    end

    drain();
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
